// ----- hdl/ppd_pkg.sv -----
// ppd_pkg: shared types and constants for the progress percentage block
// used by ppd_div, ppd_fmt and progress_percent_display; no dependencies
package ppd_pkg;

   localparam int unsigned CountWidth = 32;
   localparam int unsigned PctWidth   = 7;
   localparam int unsigned CharWidth  = 6;
   localparam int unsigned StepWidth  = 3;
   // product of a count and one hundred fits in this many bits
   localparam int unsigned ProdWidth  = CountWidth + PctWidth;

   localparam logic                 OP_ADD   = 1'b0;
   localparam logic                 OP_CLEAR = 1'b1;

   localparam logic [PctWidth-1:0]  PCT_FULL  = 7'd100;
   localparam logic [PctWidth-1:0]  PCT_RADIX = 7'd10;
   localparam logic [CharWidth-1:0] CH_ZERO   = 6'h30;
   localparam logic [CharWidth-1:0] CH_ONE    = 6'h31;
   localparam logic [CharWidth-1:0] CH_SPACE  = 6'h20;

   // fixed-point reciprocal of ten, exact for values up to one hundred
   localparam logic [7:0]           RECIP_TEN   = 8'd205;
   localparam int unsigned          RECIP_SHIFT = 11;

   typedef struct packed {
      logic [PctWidth-1:0]  percent;
      logic [CharWidth-1:0] char_hundreds;
      logic [CharWidth-1:0] char_tens;
      logic [CharWidth-1:0] char_ones;
   } text_type;

endpackage

// ----- hdl/progress_percent_display.sv -----
// progress_percent_display: saturating progress count with percent readout
// uses ppd_pkg, ppd_div (shared divider) and ppd_fmt (ascii digits)
//
//  channel | direction | handshake          | word
//  req     | in        | req_valid/req_stall | operation, amount
//  rsp     | out       | rsp_valid/rsp_stall | percent, three chars, full flag
//  csr     | in        | csr_valid/csr_ready | maximum
//
// an item goes from accept through the start, wait and emit states when not full,
// and skips the wait state when full; the next word is taken once the block is back
// in idle; the 7-step divide loop in ppd_div sets the longer path
// req_stall is high from accept until the result is loaded into the output
// register, and while csr_valid is high; a stalled result holds there until taken
// reset clears maximum and progress to zero; a csr write also clears progress
module progress_percent_display (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [ppd_pkg::CountWidth-1:0]    req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ppd_pkg::PctWidth-1:0]      rsp_percent,
   output logic [ppd_pkg::CharWidth-1:0]     rsp_char_hundreds,
   output logic [ppd_pkg::CharWidth-1:0]     rsp_char_tens,
   output logic [ppd_pkg::CharWidth-1:0]     rsp_char_ones,
   output logic                              rsp_full_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ppd_pkg::CountWidth-1:0]    csr_maximum
);
   import ppd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] maximum_ff, maximum_in;
   logic [CountWidth-1:0] progress_ff, progress_in;
   logic [PctWidth-1:0]   pct_ff, pct_in;
   logic                  full_ff, full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   text_type              text_ff, text_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  req_take;
   logic                  csr_take;
   logic [CountWidth:0]   sum;
   logic                  div_start;
   logic                  div_done;
   logic [PctWidth-1:0]   div_quotient;
   text_type              text_new;
   logic                  out_free;

   assign req_take  = req_valid & ~req_stall;
   assign csr_take  = csr_valid & csr_ready;
   assign sum       = {1'b0, progress_ff} + {1'b0, req_amount};
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign div_start = (state_ff == ST_START) & (progress_ff != maximum_ff);

   ppd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .progress (progress_ff),
      .maximum  (maximum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ppd_fmt u_fmt (
      .percent (pct_ff),
      .text    (text_new)
   );

   always_comb begin
      state_in     = state_ff;
      maximum_in   = maximum_ff;
      progress_in  = progress_ff;
      pct_in       = pct_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      text_in      = text_ff;
      rsp_full_in  = rsp_full_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               maximum_in  = csr_maximum;
               progress_in = '0;
            end else if (req_take) begin
               if (req_operation == OP_CLEAR) begin
                  progress_in = '0;
               end else if (sum >= {1'b0, maximum_ff}) begin
                  progress_in = maximum_ff;
               end else begin
                  progress_in = sum[CountWidth-1:0];
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            full_in = (progress_ff == maximum_ff);
            if (progress_ff == maximum_ff) begin
               pct_in   = PCT_FULL;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               pct_in   = div_quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               text_in      = text_new;
               rsp_full_in  = full_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pct_ff      <= pct_in;
      full_ff     <= full_in;
      text_ff     <= text_in;
      rsp_full_ff <= rsp_full_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         maximum_ff   <= '0;
         progress_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         maximum_ff   <= maximum_in;
         progress_ff  <= progress_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE) | csr_valid;
   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_percent       = text_ff.percent;
   assign rsp_char_hundreds = text_ff.char_hundreds;
   assign rsp_char_tens     = text_ff.char_tens;
   assign rsp_char_ones     = text_ff.char_ones;
   assign rsp_full_res      = rsp_full_ff;

   // progress never passes the configured maximum
   a_progress_bound: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= maximum_ff)
      else $error("progress above maximum");

   // a new word only appears after the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word without emit step");

   // full flag and a percentage of one hundred go together
   a_full_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_full_ff == (text_ff.percent == PCT_FULL)))
      else $error("full flag disagrees with percent");

   // the divider only finishes while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT))
      else $error("divider done outside wait state");

endmodule

// ----- hdl/ppd_div.sv -----
// ppd_div: shared restoring divider, one quotient bit per cycle
// forms progress*100 with shifts and divides it by maximum; uses ppd_pkg
module ppd_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ppd_pkg::CountWidth-1:0]   progress,
   input  logic [ppd_pkg::CountWidth-1:0]   maximum,
   output logic                             done,
   output logic [ppd_pkg::PctWidth-1:0]     quotient
);
   import ppd_pkg::*;

   logic [ProdWidth-1:0]  rem_ff, rem_in;
   logic [ProdWidth-2:0]  den_ff, den_in;
   logic [PctWidth-1:0]   quo_ff, quo_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ProdWidth:0]    diff;
   logic                  fits;

   assign diff = {1'b0, rem_ff} - {2'b0, den_ff};
   assign fits = ~diff[ProdWidth];

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // progress * 100 = progress * (64 + 32 + 4)
         rem_in  = {1'b0, progress, 6'b0} + {2'b0, progress, 5'b0} + {5'b0, progress, 2'b0};
         den_in  = {maximum, 6'b0};
         quo_in  = '0;
         step_in = StepWidth'(PctWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[ProdWidth-1:0];
         end
         quo_in  = {quo_ff[PctWidth-2:0], fits};
         den_in  = den_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/ppd_fmt.sv -----
// ppd_fmt: splits a percentage into three right-aligned ascii characters
// uses ppd_pkg constants and text_type
module ppd_fmt (
   input  logic [ppd_pkg::PctWidth-1:0] percent,
   output ppd_pkg::text_type            text
);
   import ppd_pkg::*;

   logic [PctWidth+7:0]  scaled;
   logic [3:0]           tens;
   logic [3:0]           tens_digit;
   logic [PctWidth-1:0]  tens_times_ten;
   logic [3:0]           ones;

   // divide by ten via reciprocal multiply
   assign scaled         = {8'b0, percent} * {7'b0, RECIP_TEN};
   assign tens           = scaled[RECIP_SHIFT+3:RECIP_SHIFT];
   assign tens_times_ten = {tens, 3'b0} + {2'b0, tens, 1'b0};
   assign ones           = 4'(percent - tens_times_ten);
   assign tens_digit     = (tens == 4'(PCT_RADIX)) ? 4'd0 : tens;

   always_comb begin
      text.percent       = percent;
      text.char_hundreds = (percent >= PCT_FULL) ? CH_ONE : CH_SPACE;
      text.char_tens     = (percent >= PCT_RADIX) ? (CH_ZERO + {2'b0, tens_digit}) : CH_SPACE;
      text.char_ones     = CH_ZERO + {2'b0, ones};
   end

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for progress_percent_display, saturating count with percent readout
// depends on ppd_pkg and progress_percent_display; directed table first, then random phases
module tb;
   import ppd_pkg::*;

   typedef struct packed {
      logic [PctWidth-1:0]  percent;
      logic [CharWidth-1:0] hundreds;
      logic [CharWidth-1:0] tens;
      logic [CharWidth-1:0] ones;
      logic                 full;
   } readout_type;

   typedef enum logic {ROW_ITEM, ROW_MAXIMUM} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  op;
      logic [CountWidth-1:0] value;
      logic                  typed;
      readout_type           want;
   } row_type;

   localparam readout_type READ_EMPTY = '{7'd0, CH_SPACE, CH_SPACE, CH_ZERO, 1'b0};
   localparam readout_type READ_HALF  = '{7'd50, CH_SPACE, CH_ZERO + 6'd5, CH_ZERO, 1'b0};
   localparam readout_type READ_FULL  = '{PCT_FULL, CH_ONE, CH_ZERO, CH_ZERO, 1'b1};
   localparam readout_type READ_NONE  = '0;

   localparam int PhaseCount    = 10;
   localparam int PhaseItems    = 72;
   localparam int HoldCycles    = 80;
   localparam int SettleCycles  = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_operation = OP_ADD;
   logic [CountWidth-1:0] req_amount = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PctWidth-1:0]   rsp_percent;
   logic [CharWidth-1:0]  rsp_char_hundreds;
   logic [CharWidth-1:0]  rsp_char_tens;
   logic [CharWidth-1:0]  rsp_char_ones;
   logic                  rsp_full_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CountWidth-1:0] csr_maximum = '0;

   // typed expectation that travels with the word on the request side
   logic                  row_typed = 1'b0;
   readout_type           row_readout = READ_NONE;

   logic [CountWidth-1:0] maximum_count = '0;
   logic [CountWidth-1:0] progress_count = '0;
   readout_type           readout_q[$];
   int                    error_count = 0;
   logic                  steady = 1'b0;
   logic                  receiver_hold = 1'b0;

   row_type directed_rows [28] = '{
      '{ROW_ITEM,    OP_ADD,   32'd0,          1'b1, READ_FULL},
      '{ROW_ITEM,    OP_ADD,   32'hFFFF_FFFF,  1'b1, READ_FULL},
      '{ROW_ITEM,    OP_CLEAR, 32'd0,          1'b1, READ_FULL},
      '{ROW_MAXIMUM, OP_ADD,   32'd200,        1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd0,          1'b1, READ_EMPTY},
      '{ROW_ITEM,    OP_ADD,   32'd100,        1'b1, READ_HALF},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd98,         1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b1, READ_FULL},
      '{ROW_ITEM,    OP_ADD,   32'd5,          1'b1, READ_FULL},
      '{ROW_ITEM,    OP_CLEAR, 32'hFFFF_FFFF,  1'b1, READ_EMPTY},
      '{ROW_ITEM,    OP_ADD,   32'd19,         1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'hFFFF_FFFF,  1'b1, READ_FULL},
      '{ROW_MAXIMUM, OP_ADD,   32'hFFFF_FFFF,  1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'hFFFF_FFFE,  1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b1, READ_FULL},
      '{ROW_ITEM,    OP_CLEAR, 32'd0,          1'b1, READ_EMPTY},
      '{ROW_ITEM,    OP_ADD,   32'h8000_0000,  1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'h7FFF_FFFF,  1'b1, READ_FULL},
      '{ROW_MAXIMUM, OP_ADD,   32'd1,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd0,          1'b1, READ_EMPTY},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b1, READ_FULL},
      '{ROW_MAXIMUM, OP_ADD,   32'd3,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd1,          1'b1, READ_FULL},
      '{ROW_MAXIMUM, OP_ADD,   32'd0,          1'b0, READ_NONE},
      '{ROW_ITEM,    OP_ADD,   32'd5,          1'b1, READ_FULL}
   };

   progress_percent_display dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_percent       (rsp_percent),
      .rsp_char_hundreds (rsp_char_hundreds),
      .rsp_char_tens     (rsp_char_tens),
      .rsp_char_ones     (rsp_char_ones),
      .rsp_full_res      (rsp_full_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_maximum       (csr_maximum)
   );

   always #5 clock = ~clock;

   // updates the progress copy for one word and returns the readout it gives
   function automatic readout_type advance_progress(input logic op,
                                                    input logic [CountWidth-1:0] amount);
      logic [CountWidth:0]   sum;
      longint unsigned       scaled;
      logic [PctWidth-1:0]   pct;
      readout_type           r;
      if (op == OP_CLEAR) begin
         progress_count = '0;
      end else begin
         sum = {1'b0, progress_count} + {1'b0, amount};
         if (sum >= {1'b0, maximum_count}) begin
            progress_count = maximum_count;
         end else begin
            progress_count = sum[CountWidth-1:0];
         end
      end
      if (progress_count >= maximum_count) begin
         pct = PCT_FULL;
      end else begin
         scaled = (64'(progress_count) * 64'(PCT_FULL)) / 64'(maximum_count);
         pct = PctWidth'(scaled);
      end
      r.percent  = pct;
      r.hundreds = (pct >= PCT_FULL) ? CH_ONE : CH_SPACE;
      r.tens     = (pct >= PCT_RADIX) ? CH_ZERO + CharWidth'((pct / PCT_RADIX) % PCT_RADIX)
                                      : CH_SPACE;
      r.ones     = CH_ZERO + CharWidth'(pct % PCT_RADIX);
      r.full     = (progress_count == maximum_count);
      return r;
   endfunction

   always @(posedge clock) begin : predict
      readout_type r;
      if (!reset && csr_valid && csr_ready) begin
         // a write restarts the count
         maximum_count  = csr_maximum;
         progress_count = '0;
      end
      if (!reset && req_valid && !req_stall) begin
         r = advance_progress(req_operation, req_amount);
         if (row_typed) begin
            r = row_readout;
         end
         readout_q.push_back(r);
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : compare
      readout_type got;
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_percent, rsp_char_hundreds, rsp_char_tens, rsp_char_ones, rsp_full_res};
         if (readout_q.size() == 0) begin
            $display("%0t: unexpected word, expected none got percent %0d", $time, rsp_percent);
            error_count++;
         end else begin
            want = readout_q.pop_front();
            check_field("percent", 32'(want.percent), 32'(got.percent));
            check_field("char_hundreds", 32'(want.hundreds), 32'(got.hundreds));
            check_field("char_tens", 32'(want.tens), 32'(got.tens));
            check_field("char_ones", 32'(want.ones), 32'(got.ones));
            check_field("full_res", 32'(want.full), 32'(got.full));
         end
      end
   end

   // receiver: random stalls, none while steady, and one long hold on request that comes first
   initial begin : receiver
      int   n;
      logic held;
      held = 1'b0;
      forever begin
         if (receiver_hold && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end else if (steady) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               rsp_stall <= 1'b1;
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 25);
            end
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic drain_results();
      req_valid <= 1'b0;
      while (readout_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_maximum(input logic [CountWidth-1:0] value);
      drain_results();
      csr_valid   <= 1'b1;
      csr_maximum <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
   endtask

   task automatic send_item(input logic op, input logic [CountWidth-1:0] amount,
                            input logic typed, input readout_type want);
      int gap;
      gap = steady ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_amount    <= amount;
      row_typed     <= typed;
      row_readout   <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CountWidth-1:0] amount;
      logic [CountWidth-1:0] next_maximum;
      logic                  op;
      int                    sel;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_MAXIMUM) begin
            write_maximum(directed_rows[k].value);
         end else begin
            send_item(directed_rows[k].op, directed_rows[k].value,
                      directed_rows[k].typed, directed_rows[k].want);
         end
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0:       next_maximum = '0;
            1:       next_maximum = '1;
            2:       next_maximum = 32'd1;
            5, 6:    next_maximum = $urandom_range(2, 1000);
            8:       next_maximum = 32'd100;
            9:       next_maximum = $urandom_range(1, 20);
            default: next_maximum = $urandom();
         endcase
         write_maximum(next_maximum);
         steady = (phase == 3 || phase == 5 || phase == 7);
         // back up the output so the block holds off the sender
         if (phase == 5) begin
            receiver_hold = 1'b1;
         end
         for (int i = 0; i < PhaseItems; i++) begin
            if (phase == 6 && i == PhaseItems / 2) begin
               drain_results();
            end
            sel = $urandom_range(0, 15);
            op  = OP_ADD;
            if (sel == 0) begin
               op     = OP_CLEAR;
               amount = $urandom();
            end else if (sel <= 2) begin
               amount = $urandom();
            end else if (sel == 3) begin
               amount = '1;
            end else if (sel == 4) begin
               amount = '0;
            end else if (maximum_count == 0) begin
               amount = $urandom_range(0, 3);
            end else begin
               amount = $urandom_range(0, maximum_count / $urandom_range(4, 40));
            end
            send_item(op, amount, 1'b0, READ_NONE);
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && readout_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
